// ----- rtl/pcx_rle_scanline_decoder_defines.svh -----
// Assertion macros shared by the PCX run-length decoder checkers.
// Stands alone; the checker file takes it in by include.
`ifndef PCX_RLE_SCANLINE_DECODER_DEFINES_SVH
`define PCX_RLE_SCANLINE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCXRLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCXRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcxrle_pkg.sv -----
// Shared types and constants of the PCX run-length scanline decoder.
// No dependencies; the decoder, datapath, controller and checker files refer to it by scoped names.
package pcxrle_pkg;

    localparam int COORD_BITS   = 16;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CNT_BITS     = 6;
    localparam int BYTE_BITS    = 8;

    localparam logic [BYTE_BITS-1:0] RUN_MARK  = 8'hC0;
    localparam logic [BYTE_BITS-1:0] RUN_COUNT = 8'h3F;

    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYTES_PER_LINE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COUNT     = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_coord_ext;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 final_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_BITS-1:0] pixel;
        logic                 last_of_item;
        logic                 frame_done;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_HOLD,
        PUSH_NEW
    } t_push_sel;

    typedef struct packed {
        logic      load;
        logic      step;
        t_push_sel push_sel;
        logic      push_last;
        logic      hold_load;
        logic      hold_clr;
        logic      end_item;
    } t_cmd;

    typedef struct packed {
        logic start_run;
        logic emit;
        logic last_step;
        logic hold_valid;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/pcx_rle_scanline_decoder.sv -----
// Top level of the PCX run-length scanline decoder (8-bit pixels, one plane).
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dp.
//
// The block takes the compressed body of a PCX image one byte per input
// transaction and returns the decoded pixels of the kept part of each scanline,
// one pixel per output transaction. A byte with both top bits set is a run
// marker whose low six bits count how often the next byte is repeated; any
// other byte is a literal pixel. Decoded bytes fill scanlines of bytes_per_line
// bytes, of which the first line_width are emitted; after line_count scanlines,
// or after the byte flagged final, the block ignores further bytes until reset.
// A literal byte is placed as a run of one, a run marker only records its count,
// and the value byte of a run of n bytes places n bytes, followed by a flush step
// when the last kept pixel of the run still sits in the hold stage. A run marker
// flagged as the final byte is itself a run of n zeros and is handled the same
// way as a value byte. A run that completes the image ends early, at the byte
// that closes the last scanline. The datapath places one decoded byte per cycle
// into the scanline, and the one-pixel hold stage lets the final pixel of an
// input byte leave marked as last_of_item. Stalls on the output side can hold
// the placing of bytes. The configuration registers are
// written while the block is idle; ready is raised only when it is waiting for
// the next input byte.
module pcx_rle_scanline_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Compressed byte input.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  pcxrle_pkg::t_in_item                 i_in_data,
    // Pixel output.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output pcxrle_pkg::t_out_item                o_out_data,
    // Configuration write port.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [pcxrle_pkg::CFG_BITS-1:0]      i_cfg_data
);

    pcxrle_pkg::t_cmd    cmd;
    pcxrle_pkg::t_status status;
    logic                cfg_we;

    // A configuration transaction completes when valid meets ready.
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // The controller sequences each input byte through its put steps and
    // decides when pixels move from the hold stage to the output register.
    pcxrle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // The datapath keeps the configuration, the run and scanline position,
    // the hold stage and the output register.
    pcxrle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/pcxrle_dp.sv -----
// Datapath of the PCX run-length decoder: configuration, run and scanline state,
// pixel hold stage and output register. Depends on pcxrle_pkg.
module pcxrle_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcxrle_pkg::t_in_item                   i_in_data,
    input  logic                                   i_cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pcxrle_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                   i_out_stall,
    input  pcxrle_pkg::t_cmd                       i_cmd,
    output pcxrle_pkg::t_status                    o_status,
    output logic                                   o_out_valid,
    output pcxrle_pkg::t_out_item                  o_out_data
);

    pcxrle_pkg::t_coord r_line_width;
    pcxrle_pkg::t_coord r_bytes_per_line;
    pcxrle_pkg::t_coord r_line_count;

    logic                                r_run_pending;
    logic [pcxrle_pkg::CNT_BITS-1:0]     r_run_len;
    pcxrle_pkg::t_coord                  r_column;
    pcxrle_pkg::t_coord                  r_row;
    logic                                r_finished;

    logic [pcxrle_pkg::CNT_BITS-1:0]     r_cnt;
    logic [pcxrle_pkg::BYTE_BITS-1:0]    r_val;
    logic                                r_fin;

    logic [pcxrle_pkg::BYTE_BITS-1:0]    r_hold_pix;
    logic                                r_hold_fd;
    logic                                r_hold_valid;

    logic                                r_out_valid;
    pcxrle_pkg::t_out_item               r_out_data;

    pcxrle_pkg::t_coord                  bpl_eff;
    pcxrle_pkg::t_coord                  lc_eff;
    pcxrle_pkg::t_coord                  kept;
    pcxrle_pkg::t_coord_ext              row_inc;
    pcxrle_pkg::t_coord_ext              col_inc;
    logic                                last_row;
    logic                                wrap;
    logic                                emit;
    logic                                fd_now;
    logic                                put_fin;
    logic                                is_mark;
    logic [pcxrle_pkg::CNT_BITS-1:0]     mark_cnt;
    logic [pcxrle_pkg::CNT_BITS-1:0]     start_cnt;
    logic [pcxrle_pkg::BYTE_BITS-1:0]    start_val;
    logic                                out_free;

    // Scanline geometry; a zero bytes-per-line or line-count register behaves as one.
    always_comb begin
        bpl_eff  = (r_bytes_per_line == '0) ? pcxrle_pkg::t_coord'(1) : r_bytes_per_line;
        lc_eff   = (r_line_count == '0) ? pcxrle_pkg::t_coord'(1) : r_line_count;
        kept     = (r_line_width < bpl_eff) ? r_line_width : bpl_eff;
        row_inc  = {1'b0, r_row} + pcxrle_pkg::t_coord_ext'(1);
        col_inc  = {1'b0, r_column} + pcxrle_pkg::t_coord_ext'(1);
        last_row = row_inc >= {1'b0, lc_eff};
        wrap     = (col_inc >= {1'b0, bpl_eff}) ||
                   (col_inc[pcxrle_pkg::COORD_BITS-1:0] == '0);
        emit     = r_column < kept;
        fd_now   = last_row && (col_inc == {1'b0, kept});
        put_fin  = wrap && last_row;
    end

    // How an incoming byte starts its work.
    always_comb begin
        is_mark  = (i_in_data.data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
        mark_cnt = pcxrle_pkg::CNT_BITS'(i_in_data.data_byte & pcxrle_pkg::RUN_COUNT);
        if (r_run_pending) begin
            start_cnt = r_run_len;
        end else if (is_mark) begin
            start_cnt = i_in_data.final_byte ? mark_cnt : '0;
        end else begin
            start_cnt = pcxrle_pkg::CNT_BITS'(1);
        end
        start_val = (!r_run_pending && is_mark) ? '0 : i_in_data.data_byte;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.start_run  = !r_finished && (start_cnt != '0);
        o_status.emit       = emit;
        o_status.last_step  = (r_cnt == pcxrle_pkg::CNT_BITS'(1)) || put_fin;
        o_status.hold_valid = r_hold_valid;
        o_status.out_free   = out_free;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width     <= pcxrle_pkg::t_coord'(1);
            r_bytes_per_line <= pcxrle_pkg::t_coord'(1);
            r_line_count     <= pcxrle_pkg::t_coord'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcxrle_pkg::REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[pcxrle_pkg::COORD_BITS-1:0];
                end
                pcxrle_pkg::REG_BYTES_PER_LINE: begin
                    r_bytes_per_line <= i_cfg_data[pcxrle_pkg::COORD_BITS-1:0];
                end
                pcxrle_pkg::REG_LINE_COUNT: begin
                    r_line_count <= i_cfg_data[pcxrle_pkg::COORD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Run and scanline state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending <= 1'b0;
            r_run_len     <= '0;
            r_column      <= '0;
            r_row         <= '0;
            r_finished    <= 1'b0;
            r_cnt         <= '0;
            r_fin         <= 1'b0;
        end else begin
            if (i_cmd.load && !r_finished) begin
                r_cnt <= start_cnt;
                r_fin <= i_in_data.final_byte;
                if (r_run_pending) begin
                    r_run_pending <= 1'b0;
                    r_run_len     <= '0;
                end else if (is_mark && !i_in_data.final_byte) begin
                    r_run_pending <= 1'b1;
                    r_run_len     <= mark_cnt;
                end
                if (i_in_data.final_byte && (start_cnt == '0)) begin
                    r_finished <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_cnt <= r_cnt - pcxrle_pkg::CNT_BITS'(1);
                if (wrap) begin
                    r_column <= '0;
                    if (last_row) begin
                        r_finished <= 1'b1;
                    end else begin
                        r_row <= row_inc[pcxrle_pkg::COORD_BITS-1:0];
                    end
                end else begin
                    r_column <= col_inc[pcxrle_pkg::COORD_BITS-1:0];
                end
            end
            if (i_cmd.end_item && r_fin) begin
                r_finished <= 1'b1;
            end
        end
    end

    // Value register for the byte being repeated.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= start_val;
        end
    end

    // One-pixel hold stage, so that the last pixel of an item is known when it leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.hold_load) begin
            r_hold_valid <= 1'b1;
        end else if (i_cmd.hold_clr) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_load) begin
            r_hold_pix <= r_val;
            r_hold_fd  <= fd_now;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.push_sel)
                pcxrle_pkg::PUSH_HOLD,
                pcxrle_pkg::PUSH_NEW: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.push_sel)
            pcxrle_pkg::PUSH_HOLD: begin
                r_out_data.pixel        <= r_hold_pix;
                r_out_data.last_of_item <= i_cmd.push_last;
                r_out_data.frame_done   <= r_hold_fd;
            end
            pcxrle_pkg::PUSH_NEW: begin
                r_out_data.pixel        <= r_val;
                r_out_data.last_of_item <= i_cmd.push_last;
                r_out_data.frame_done   <= fd_now;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/pcxrle_ctrl.sv -----
// Controller state machine of the PCX run-length decoder.
// Depends on pcxrle_pkg; drives the datapath through a command struct.
module pcxrle_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  pcxrle_pkg::t_status  i_status,
    output pcxrle_pkg::t_cmd     o_cmd,
    output logic                 o_in_stall,
    output logic                 o_cfg_ready
);

    pcxrle_pkg::t_state r_state;
    pcxrle_pkg::t_state n_state;
    logic               need_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcxrle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        // A step needs the output register when it releases a pixel.
        need_push   = i_status.hold_valid ? (i_status.emit || i_status.last_step)
                                          : (i_status.emit && i_status.last_step);
        unique case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.start_run) begin
                        n_state = pcxrle_pkg::ST_RUN;
                    end
                end
            end
            pcxrle_pkg::ST_RUN: begin
                if (!need_push || i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.hold_valid && i_status.emit) begin
                        o_cmd.push_sel = pcxrle_pkg::PUSH_HOLD;
                        o_cmd.hold_load = 1'b1;
                        if (i_status.last_step) begin
                            n_state = pcxrle_pkg::ST_FLUSH;
                        end
                    end else if (i_status.hold_valid && i_status.last_step) begin
                        o_cmd.push_sel  = pcxrle_pkg::PUSH_HOLD;
                        o_cmd.push_last = 1'b1;
                        o_cmd.hold_clr  = 1'b1;
                        o_cmd.end_item  = 1'b1;
                        n_state         = pcxrle_pkg::ST_IDLE;
                    end else if (i_status.emit && i_status.last_step) begin
                        o_cmd.push_sel  = pcxrle_pkg::PUSH_NEW;
                        o_cmd.push_last = 1'b1;
                        o_cmd.end_item  = 1'b1;
                        n_state         = pcxrle_pkg::ST_IDLE;
                    end else if (i_status.emit) begin
                        o_cmd.hold_load = 1'b1;
                    end else if (i_status.last_step) begin
                        o_cmd.end_item = 1'b1;
                        n_state        = pcxrle_pkg::ST_IDLE;
                    end
                end
            end
            pcxrle_pkg::ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push_sel  = pcxrle_pkg::PUSH_HOLD;
                    o_cmd.push_last = 1'b1;
                    o_cmd.hold_clr  = 1'b1;
                    o_cmd.end_item  = 1'b1;
                    n_state         = pcxrle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcxrle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/pcxrle_chk.sv -----
// Port-level checker of the PCX run-length decoder, bound to the top level.
// Depends on pcxrle_pkg and pcx_rle_scanline_decoder_defines.svh.
`include "pcx_rle_scanline_decoder_defines.svh"

module pcxrle_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  pcxrle_pkg::t_out_item                o_out_data,
    input  logic                                 o_cfg_ready
);

    logic r_seen_done;

    // Remembers that the pixel completing the image has been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.frame_done) begin
            r_seen_done <= 1'b1;
        end
    end

    `PCXRLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled pixel changed or vanished")

    `PCXRLE_ASSERT_SAME(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.frame_done,
        o_out_data.last_of_item, "frame completion not on the last pixel of its byte")

    `PCXRLE_ASSERT_SAME(a_quiet_after_done, i_clk, i_rst_n, r_seen_done,
        !o_out_valid, "pixel delivered after the image was complete")

    `PCXRLE_ASSERT_SAME(a_cfg_only_idle, i_clk, i_rst_n, o_cfg_ready,
        !o_in_stall, "configuration ready while a byte is in flight")

endmodule

bind pcx_rle_scanline_decoder pcxrle_chk u_chk (.*);
